FILE: rtl/v3a_pkg.sv
// Shared types, constants and op codes for the 3D vector unit.
`default_nettype none
package v3a_pkg;
  localparam int FRAC_BITS = 14;
  localparam int IN_WIDTH  = 18;
  localparam int OUT_WIDTH = 16;
  // Cross terms are 2*IN_WIDTH+1 bits signed; the magnitude needs 2*IN_WIDTH bits.
  localparam int MAG_W     = 2 * IN_WIDTH;
  localparam int NORM_W    = 30;   // the largest normalized magnitude lies in [2^29, 2^30)
  localparam int SUM_W     = 2 * NORM_W + 2;
  localparam int LEN_W     = NORM_W + 1;
  localparam int NUM_W     = NORM_W + FRAC_BITS;
  localparam int Q_W       = FRAC_BITS + 2;
  localparam int SH_W      = 7;

  typedef enum logic [2:0] {
    OP_NORM  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_CROSS = 3'd3,
    OP_CMP   = 3'd4,
    OP_DIV   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQ   = 2'd0,
    ORD_LESS = 2'd1,
    ORD_MORE = 2'd2
  } order_t;

  // Sideband carried with each word through the pipeline.
  typedef struct packed {
    logic       is_vec;
    logic       zero;
    logic [2:0] neg;
    logic [1:0] order;
    logic       error;
  } side_t;
endpackage
`default_nettype wire

FILE: rtl/v3a_front.sv
// Front end: forms the intermediate vector, signs, magnitudes and compare result.
`default_nettype none
module v3a_front (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [2:0]                      op,
  input  wire logic signed [v3a_pkg::IN_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z,
  output logic [v3a_pkg::MAG_W-1:0]            m0, m1, m2,
  output v3a_pkg::side_t                       side
);
  import v3a_pkg::*;

  localparam int PW = 2 * IN_WIDTH + 1;
  localparam int SW = IN_WIDTH + 2;

  logic signed [PW-1:0] c0, c1, c2;
  logic signed [SW-1:0] sa, sb;
  logic [MAG_W-1:0]     g0, g1, g2;
  side_t                s;

  function automatic logic [MAG_W-1:0] mag(input logic signed [PW-1:0] v);
    logic [PW-1:0] u;
    u = v[PW-1] ? (~v + 1'b1) : v;
    return u[MAG_W-1:0];
  endfunction

  always_comb begin
    c0 = '0; c1 = '0; c2 = '0;
    sa = SW'(a_x) + SW'(a_y) + SW'(a_z);
    sb = SW'(b_x) + SW'(b_y) + SW'(b_z);
    s = '0;
    case (op)
      OP_NORM: begin
        c0 = PW'(a_x); c1 = PW'(a_y); c2 = PW'(a_z); s.is_vec = 1'b1;
      end
      OP_ADD: begin
        c0 = PW'(a_x) + PW'(b_x); c1 = PW'(a_y) + PW'(b_y); c2 = PW'(a_z) + PW'(b_z);
        s.is_vec = 1'b1;
      end
      OP_SUB: begin
        c0 = PW'(a_x) - PW'(b_x); c1 = PW'(a_y) - PW'(b_y); c2 = PW'(a_z) - PW'(b_z);
        s.is_vec = 1'b1;
      end
      OP_CROSS: begin
        c0 = PW'(a_y * b_z) - PW'(a_z * b_y);
        c1 = PW'(a_z * b_x) - PW'(a_x * b_z);
        c2 = PW'(a_x * b_y) - PW'(a_y * b_x);
        s.is_vec = 1'b1;
      end
      OP_CMP: s.order = (sa < sb) ? ORD_LESS : (sa > sb) ? ORD_MORE : ORD_EQ;
      default: s.error = 1'b1;
    endcase
    g0 = mag(c0); g1 = mag(c1); g2 = mag(c2);
    s.neg  = {c2[PW-1], c1[PW-1], c0[PW-1]};
    s.zero = (c0 == '0) && (c1 == '0) && (c2 == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= g0; m1 <= g1; m2 <= g2; side <= s;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/v3a_norm.sv
// Normalizing shift of three magnitudes so the largest lands in [2^29, 2^30).
`default_nettype none
module v3a_norm (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [v3a_pkg::MAG_W-1:0]    m0, m1, m2,
  input  wire v3a_pkg::side_t               side_in,
  output logic [v3a_pkg::NORM_W-1:0]        n0, n1, n2,
  output v3a_pkg::side_t                    side
);
  import v3a_pkg::*;

  logic [MAG_W-1:0]  top;
  logic [SH_W-1:0]   lead;
  logic [MAG_W+NORM_W-1:0] w0, w1, w2;

  // Stage A: find the leading one of the largest magnitude.
  logic [MAG_W-1:0]  r0, r1, r2;
  logic [SH_W-1:0]   rlead;
  side_t             rside;

  always_comb begin
    top = m0 | m1 | m2;   // same leading bit as the max
    lead = '0;
    for (int i = 0; i < MAG_W; i++)
      if (top[i]) lead = SH_W'(i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= m0; r1 <= m1; r2 <= m2; rlead <= lead; rside <= side_in;
    end
  end

  // Stage B: place bit rlead at position NORM_W-1; low bits shifted out are dropped.
  always_comb begin
    w0 = {r0, {NORM_W{1'b0}}} >> (rlead + 1'b1);
    w1 = {r1, {NORM_W{1'b0}}} >> (rlead + 1'b1);
    w2 = {r2, {NORM_W{1'b0}}} >> (rlead + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0 <= w0[NORM_W-1:0];
      n1 <= w1[NORM_W-1:0];
      n2 <= w2[NORM_W-1:0];
      side <= rside;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/v3a_sqrt.sv
// Squares, sum and pipelined integer square root, one result bit per stage.
`default_nettype none
module v3a_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [v3a_pkg::NORM_W-1:0]   n0, n1, n2,
  input  wire v3a_pkg::side_t               side_in,
  output logic [v3a_pkg::NORM_W-1:0]        o0, o1, o2,
  output logic [v3a_pkg::LEN_W-1:0]         len,
  output v3a_pkg::side_t                    side
);
  import v3a_pkg::*;

  localparam int ST = LEN_W;

  logic [2*NORM_W-1:0] q0, q1, q2;
  logic [NORM_W-1:0]   p0, p1, p2;
  side_t               ps;

  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= n0 * n0; q1 <= n1 * n1; q2 <= n2 * n2;
      p0 <= n0; p1 <= n1; p2 <= n2; ps <= side_in;
    end
  end

  // rem holds the sum minus root squared.
  logic [SUM_W-1:0]  rem [ST+1];
  logic [LEN_W-1:0]  root[ST+1];
  logic [NORM_W-1:0] k0[ST+1], k1[ST+1], k2[ST+1];
  side_t             ks[ST+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= SUM_W'(q0) + SUM_W'(q1) + SUM_W'(q2);
      root[0] <= '0;
      k0[0] <= p0; k1[0] <= p1; k2[0] <= p2; ks[0] <= ps;
    end
  end

  for (genvar g = 0; g < ST; g++) begin : g_root
    localparam int B = ST - 1 - g;
    logic [SUM_W+1:0] trial;
    logic [SUM_W+1:0] cur;
    logic [LEN_W-1:0] rt;
    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B); root has no bits below B+1
    always_comb begin
      rt    = root[g] | (LEN_W'(1) << B);
      trial = ((SUM_W+2)'(root[g]) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));
      cur   = (SUM_W+2)'(rem[g]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= (trial <= cur) ? SUM_W'(cur - trial) : rem[g];
        root[g+1] <= (trial <= cur) ? rt : root[g];
        k0[g+1] <= k0[g]; k1[g+1] <= k1[g]; k2[g+1] <= k2[g]; ks[g+1] <= ks[g];
      end
    end
  end

  assign o0 = k0[ST]; assign o1 = k1[ST]; assign o2 = k2[ST];
  assign len = root[ST];
  assign side = ks[ST];
endmodule
`default_nettype wire

FILE: rtl/v3a_div.sv
// Pipelined restoring divide of three scaled magnitudes by the length, then sign.
`default_nettype none
module v3a_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [v3a_pkg::NORM_W-1:0]   n0, n1, n2,
  input  wire logic [v3a_pkg::LEN_W-1:0]    len,
  input  wire v3a_pkg::side_t               side_in,
  output logic signed [v3a_pkg::OUT_WIDTH-1:0] r_x, r_y, r_z,
  output logic [1:0]                        order,
  output logic                              error
);
  import v3a_pkg::*;

  localparam int ST = Q_W;
  localparam int RW = LEN_W + 1;

  // Quotient < 2^Q_W since num < 2^(NORM_W+FRAC_BITS) and len >= 2^(NORM_W-1).
  logic [RW-1:0]    rm [3][ST+1];
  logic [NUM_W-1:0] nm [3][ST+1];
  logic [Q_W-1:0]   qt [3][ST+1];
  logic [LEN_W-1:0] d  [ST+1];
  side_t            ks [ST+1];

  // Top bits of the numerator above the quotient bits form the starting remainder.
  function automatic logic [NUM_W-Q_W-1:0] nm_hi(input logic [NORM_W-1:0] v);
    logic [NUM_W-1:0] t;
    t = {v, {FRAC_BITS{1'b0}}};
    return t[NUM_W-1:Q_W];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0][0] <= {n0, {FRAC_BITS{1'b0}}};
      nm[1][0] <= {n1, {FRAC_BITS{1'b0}}};
      nm[2][0] <= {n2, {FRAC_BITS{1'b0}}};
      rm[0][0] <= RW'(nm_hi(n0));
      rm[1][0] <= RW'(nm_hi(n1));
      rm[2][0] <= RW'(nm_hi(n2));
      qt[0][0] <= '0;
      qt[1][0] <= '0;
      qt[2][0] <= '0;
      d[0] <= len; ks[0] <= side_in;
    end
  end

  for (genvar g = 0; g < ST; g++) begin : g_div
    localparam int B = ST - 1 - g;
    for (genvar c = 0; c < 3; c++) begin : g_c
      logic [RW-1:0] sh;
      always_comb sh = {rm[c][g][RW-2:0], nm[c][g][B]};
      always_ff @(posedge clk) begin
        if (en) begin
          nm[c][g+1] <= nm[c][g];
          if (sh >= RW'(d[g])) begin
            rm[c][g+1] <= sh - RW'(d[g]);
            qt[c][g+1] <= qt[c][g] | (Q_W'(1) << B);
          end else begin
            rm[c][g+1] <= sh;
            qt[c][g+1] <= qt[c][g];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[g+1] <= d[g]; ks[g+1] <= ks[g];
      end
    end
  end

  function automatic logic [OUT_WIDTH-1:0] fin(input logic [Q_W-1:0] q, input logic n,
                                               input logic ok);
    logic [OUT_WIDTH-1:0] v;
    v = OUT_WIDTH'(q);
    if (!ok) return '0;
    return n ? (~v + 1'b1) : v;
  endfunction

  logic ok;
  assign ok = ks[ST].is_vec && !ks[ST].zero;
  assign r_x   = fin(qt[0][ST], ks[ST].neg[0], ok);
  assign r_y   = fin(qt[1][ST], ks[ST].neg[1], ok);
  assign r_z   = fin(qt[2][ST], ks[ST].neg[2], ok);
  assign order = ks[ST].order;
  assign error = ks[ST].error;
endmodule
`default_nettype wire

FILE: rtl/vec3_unit_alu_unit.sv
// Top level of the 3D vector unit: pipeline control and output register.
`default_nettype none
// 3D vector unit: normalize, add, subtract and cross product scaled to unit
// length (Q1.14, truncated), compare by component sum, divide flags error.
// Input channel: valid/ready with op and vectors a, b (Q3.14).
// Output channel: valid/ready with r_x, r_y, r_z, order, error.
// One word per cycle sustained while the receiver accepts. Register stages:
// front 1, normalize 2, square root 2 + 31, divide 1 + 16, output 1. The
// depth is set by the bit-per-stage square root and divider.
// The whole pipeline advances together; when the receiver stalls with a word
// waiting at the output, the pipeline freezes and in_ready drops, so nothing
// is lost or repeated. Ready stays high while the output slot is free or
// being drained; bubbles inside the pipeline are not removed during a stall.
// Reset clears every valid bit; data registers are not reset.
module vec3_unit_alu_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          op,
  input  wire logic signed [v3a_pkg::IN_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [v3a_pkg::OUT_WIDTH-1:0]     r_x, r_y, r_z,
  output logic [1:0]                               order,
  output logic                                     error
);
  import v3a_pkg::*;

  localparam int DEPTH = 1 + 2 + 2 + LEN_W + 1 + Q_W;

  logic [DEPTH-1:0] vld;
  logic             en;

  logic [MAG_W-1:0]  m0, m1, m2;
  logic [NORM_W-1:0] n0, n1, n2, o0, o1, o2;
  logic [LEN_W-1:0]  len;
  side_t             s1, s2, s3;
  logic signed [OUT_WIDTH-1:0] dx, dy, dz;
  logic [1:0]        dord;
  logic              derr;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x <= dx; r_y <= dy; r_z <= dz; order <= dord; error <= derr;
    end
  end

  v3a_front u_front (
    .clk, .en, .op, .a_x, .a_y, .a_z, .b_x, .b_y, .b_z,
    .m0, .m1, .m2, .side(s1)
  );

  v3a_norm u_norm (
    .clk, .en, .m0, .m1, .m2, .side_in(s1), .n0, .n1, .n2, .side(s2)
  );

  v3a_sqrt u_sqrt (
    .clk, .en, .n0, .n1, .n2, .side_in(s2), .o0, .o1, .o2, .len, .side(s3)
  );

  v3a_div u_div (
    .clk, .en, .n0(o0), .n1(o1), .n2(o2), .len, .side_in(s3),
    .r_x(dx), .r_y(dy), .r_z(dz), .order(dord), .error(derr)
  );
endmodule
`default_nettype wire
